[hw/rtl/longest_bounded_step_subsequence_macros.svh]
// Assertion macros for the checker of the bounded-step subsequence block.
// No dependencies; included by the checker file.
`ifndef LONGEST_BOUNDED_STEP_SUBSEQUENCE_MACROS_SVH
`define LONGEST_BOUNDED_STEP_SUBSEQUENCE_MACROS_SVH

// Property checked on every clock edge outside reset.
`define LBSS_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define LBSS_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/lbss_pkg.sv]
// Package of the bounded-step subsequence block: sizes, stored entry type.
// No dependencies; used by the cell, the top level and the checker.
package lbss_pkg;

    localparam int MAX_ITEMS  = 1024;
    localparam int VALUE_BITS = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int GAP_BITS   = 16;
    localparam int LEN_BITS   = 11;
    localparam int ADDR_BITS  = $clog2(MAX_ITEMS);
    localparam int CNT_BITS   = $clog2(MAX_ITEMS + 1);
    localparam int CMP_BITS   = (VALUE_BITS > GAP_BITS) ? VALUE_BITS : GAP_BITS;
    localparam int M_TDATA_BITS = ((2 * LEN_BITS + 7) / 8) * 8;
    localparam int S_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

    // One stored entry: a value and the best length ending at it.
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [CNT_BITS-1:0]   len;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

endpackage

[hw/rtl/longest_bounded_step_subsequence.sv]
// Top level of the bounded-step subsequence block: control and the cell ring.
// Depends on lbss_pkg and lbss_cell.
//
// Use:
//   s_ channel: one request per value, s_tdata = sample_value, s_tuser = start_new.
//   m_ channel: one result per request, m_tdata = length_here, longest_so_far;
//   m_tuser = store_full.
//   cfg channel: writes max_gap; always ready, write only while the block is idle.
// Timing:
//   A request is taken only while no other is in work. The stored entries sit in a
//   ring of MAX_ITEMS cells that rotates once per request past a single
//   compare unit at the head, one entry per cycle, and then goes to ST_DONE, where
//   the entry is stored and the result is registered. A request on a full store
//   skips the rotation and goes from ST_IDLE straight to ST_DONE.
//   The result sits in an output register; a new request is accepted while it
//   waits. If the receiver still stalls when the next result is ready, the block
//   holds that result and takes no request until the register frees up.
// Reset:
//   Clears the entry count, the running maximum, max_gap, the state and the result
//   valid. The ring contents are not cleared; only entries below the count are compared.
module longest_bounded_step_subsequence (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [lbss_pkg::S_TDATA_BITS-1:0]    s_tdata,  // [15:0] sample_value
    input  logic                                 s_tuser,  // [0] start_new
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [lbss_pkg::M_TDATA_BITS-1:0]    m_tdata,  // [10:0] length_here,
                                                           // [21:11] longest_so_far
    output logic                                 m_tuser,  // [0] store_full
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lbss_pkg::GAP_BITS-1:0]        cfg_data  // max_gap
);
    import lbss_pkg::*;

    state_t                state_reg, state_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [CNT_BITS-1:0]   best_reg, best_next;
    logic [GAP_BITS-1:0]   gap_reg, gap_next;
    logic [VALUE_BITS-1:0] sample_reg, sample_next;
    logic                  full_reg, full_next;
    logic [ADDR_BITS-1:0]  scan_reg, scan_next;
    logic [CNT_BITS-1:0]   prev_reg, prev_next;
    logic [LEN_BITS-1:0]   out_len_reg, out_len_next;
    logic [LEN_BITS-1:0]   out_best_reg, out_best_next;
    logic                  out_full_reg, out_full_next;
    logic                  m_valid_reg, m_valid_next;

    entry_t                ring [MAX_ITEMS];
    entry_t                head;
    entry_t                new_entry;
    logic                  shift_en;
    logic                  store_en;
    logic [VALUE_BITS-1:0] diff;
    logic                  hit;
    logic                  out_free;
    logic [CNT_BITS-1:0]   len_here;
    logic [CNT_BITS-1:0]   best_upd;
    logic [CNT_BITS-1:0]   count_eff;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;
    assign shift_en  = (state_reg == ST_SCAN);
    assign store_en  = (state_reg == ST_DONE) && out_free && !full_reg;
    assign head      = ring[0];

    // Compare unit at the head of the ring.
    assign diff = (head.value >= sample_reg) ? (head.value - sample_reg)
                                             : (sample_reg - head.value);
    assign hit  = (CNT_BITS'(scan_reg) < count_reg)
                  && (CMP_BITS'(diff) <= CMP_BITS'(gap_reg))
                  && (head.len > prev_reg);

    assign len_here  = prev_reg + CNT_BITS'(1);
    assign best_upd  = (len_here > best_reg) ? len_here : best_reg;
    assign count_eff = s_tuser ? '0 : count_reg;

    assign new_entry.value = sample_reg;
    assign new_entry.len   = len_here;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ITEMS; gi++) begin : g_cell
            lbss_cell u_cell (
                .aclk          (aclk),
                .shift_en      (shift_en),
                .load_en       (store_en && (count_reg[ADDR_BITS-1:0] == ADDR_BITS'(gi))),
                .load_entry    (new_entry),
                .neighbor_entry(ring[(gi + 1) % MAX_ITEMS]),
                .cell_entry    (ring[gi])
            );
        end
    endgenerate

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        best_next     = best_reg;
        gap_next      = gap_reg;
        sample_next   = sample_reg;
        full_next     = full_reg;
        scan_next     = scan_reg;
        prev_next     = prev_reg;
        out_len_next  = out_len_reg;
        out_best_next = out_best_reg;
        out_full_next = out_full_reg;
        m_valid_next  = m_valid_reg;

        if (cfg_valid && cfg_ready) begin
            gap_next = cfg_data;
        end
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    sample_next = s_tdata[VALUE_BITS-1:0];
                    count_next  = count_eff;
                    best_next   = s_tuser ? '0 : best_reg;
                    full_next   = (count_eff == CNT_BITS'(MAX_ITEMS));
                    scan_next   = '0;
                    prev_next   = '0;
                    state_next  = (count_eff == CNT_BITS'(MAX_ITEMS)) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    prev_next = head.len;
                end
                scan_next = scan_reg + ADDR_BITS'(1);
                // ring is back in its home alignment after the last shift
                if (scan_reg == ADDR_BITS'(MAX_ITEMS - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    out_full_next = full_reg;
                    if (full_reg) begin
                        out_len_next  = '0;
                        out_best_next = best_reg[LEN_BITS-1:0];
                    end else begin
                        out_len_next  = len_here[LEN_BITS-1:0];
                        out_best_next = best_upd[LEN_BITS-1:0];
                        count_next    = count_reg + CNT_BITS'(1);
                        best_next     = best_upd;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            best_reg    <= '0;
            gap_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            best_reg    <= best_next;
            gap_reg     <= gap_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sample_reg   <= sample_next;
        full_reg     <= full_next;
        scan_reg     <= scan_next;
        prev_reg     <= prev_next;
        out_len_reg  <= out_len_next;
        out_best_reg <= out_best_next;
        out_full_reg <= out_full_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_BITS - 2 * LEN_BITS){1'b0}}, out_best_reg, out_len_reg};
    assign m_tuser  = out_full_reg;

endmodule

[hw/rtl/lbss_cell.sv]
// One cell of the storage ring: holds an entry and passes it to its neighbor.
// Depends on lbss_pkg.
module lbss_cell (
    input  logic            aclk,
    input  logic            shift_en,
    input  logic            load_en,
    input  lbss_pkg::entry_t load_entry,
    input  lbss_pkg::entry_t neighbor_entry,
    output lbss_pkg::entry_t cell_entry
);
    import lbss_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb begin
        entry_next = entry_reg;
        if (load_en) begin
            entry_next = load_entry;
        end else if (shift_en) begin
            entry_next = neighbor_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign cell_entry = entry_reg;

endmodule

[hw/rtl/lbss_checker.sv]
// Port-level checker for the bounded-step subsequence block, bound to the top.
// Depends on lbss_pkg and longest_bounded_step_subsequence_macros.svh.
`include "longest_bounded_step_subsequence_macros.svh"

module lbss_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [lbss_pkg::M_TDATA_BITS-1:0] m_tdata,
    input logic                              m_tuser
);
    import lbss_pkg::*;

    logic [LEN_BITS-1:0] len_here;
    logic [LEN_BITS-1:0] longest;

    assign len_here = m_tdata[LEN_BITS-1:0];
    assign longest  = m_tdata[2*LEN_BITS-1:LEN_BITS];

    `LBSS_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `LBSS_ASSERT(a_full_zero, aclk, aresetn, m_tvalid && m_tuser |-> len_here == '0, "ignored value reports a length")
    `LBSS_ASSERT(a_len_bound, aclk, aresetn, m_tvalid && !m_tuser |-> len_here != '0 && longest >= len_here, "length above running maximum")
    `LBSS_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind longest_bounded_step_subsequence lbss_checker u_lbss_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);

[sim/testbench.sv]
// Self-checking bench for longest_bounded_step_subsequence: a queue-fed stream driver,
// a result monitor and a scoreboard that recomputes each subsequence length.
// Depends on lbss_pkg and the top level of the block.
module testbench;
    import lbss_pkg::*;

    localparam int CYCLE_LIMIT = 6_000_000;
    localparam int HOLDOFF_CYCLES = 3000;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] value;
        logic                   start_new;
    } sample_req_t;

    typedef struct packed {
        logic [LEN_BITS-1:0] length_here;
        logic [LEN_BITS-1:0] longest_so_far;
        logic                store_full;
    } seq_result_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [S_TDATA_BITS-1:0] s_tdata = '0;
    logic                    s_tuser = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] m_tdata;
    logic                    m_tuser;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [GAP_BITS-1:0]     cfg_data = '0;

    // scoreboard copy of the block state
    logic [VALUE_BITS-1:0] seen_values [MAX_ITEMS];
    logic [LEN_BITS-1:0]   seen_lengths [MAX_ITEMS];
    int                    seen_count = 0;
    logic [LEN_BITS-1:0]   best_len = '0;
    logic [GAP_BITS-1:0]   gap_limit = '0;

    sample_req_t pending_samples [$];
    seq_result_t expected_lengths [$];
    sample_req_t next_req;
    seq_result_t got;
    int          samples_in_flight = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          mismatches = 0;
    int          cycle_count = 0;
    logic        holdoff_go = 1'b0;
    logic        rx_hold = 1'b0;

    longest_bounded_step_subsequence dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [15:0] sample_value
        .s_tuser   (s_tuser),   // [0] start_new
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [10:0] length_here, [21:11] longest_so_far
        .m_tuser   (m_tuser),   // [0] store_full
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)   // max_gap
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Longest chain ending at this value: one more than the best stored length among
    // entries within the gap.
    function automatic void predict_length(logic [VALUE_BITS-1:0] value, logic start_new);
        seq_result_t         r;
        logic [LEN_BITS-1:0] prior;
        logic [VALUE_BITS-1:0] spread;
        int                  i;
        r = '0;
        prior = '0;
        if (start_new) begin
            seen_count = 0;
            best_len = '0;
        end
        if (seen_count >= MAX_ITEMS) begin
            r.store_full = 1'b1;
        end else begin
            for (i = 0; i < seen_count; i++) begin
                spread = (seen_values[i] >= value) ? seen_values[i] - value
                                                   : value - seen_values[i];
                if (spread <= gap_limit && seen_lengths[i] > prior) begin
                    prior = seen_lengths[i];
                end
            end
            r.length_here = prior + 1'b1;
            seen_values[seen_count] = value;
            seen_lengths[seen_count] = r.length_here;
            seen_count++;
            if (r.length_here > best_len) begin
                best_len = r.length_here;
            end
        end
        r.longest_so_far = best_len;
        expected_lengths.insert(expected_lengths.size(), r);
    endfunction

    // Stream driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_length(s_tdata[VALUE_BITS-1:0], s_tuser);
                samples_in_flight--;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_req = pending_samples.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= next_req.value;
                    s_tuser <= next_req.start_new;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_lengths.size() == 0) begin
                    $error("result with no request outstanding: tdata=%h tuser=%b",
                           m_tdata, m_tuser);
                    mismatches++;
                end else begin
                    got = expected_lengths.pop_front();
                    if (m_tdata[LEN_BITS-1:0] !== got.length_here) begin
                        $error("length_here: expected %0d, got %0d",
                               got.length_here, m_tdata[LEN_BITS-1:0]);
                        mismatches++;
                    end
                    if (m_tdata[2*LEN_BITS-1:LEN_BITS] !== got.longest_so_far) begin
                        $error("longest_so_far: expected %0d, got %0d",
                               got.longest_so_far, m_tdata[2*LEN_BITS-1:LEN_BITS]);
                        mismatches++;
                    end
                    if (m_tuser !== got.store_full) begin
                        $error("store_full: expected %0b, got %0b", got.store_full, m_tuser);
                        mismatches++;
                    end
                end
            end
            m_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off so the output register fills and s_tready drops
    initial begin
        wait (holdoff_go);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLDOFF_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic queue_sample(logic [VALUE_BITS-1:0] value, logic start_new);
        sample_req_t req;
        req.value = value;
        req.start_new = start_new;
        pending_samples.insert(pending_samples.size(), req);
        samples_in_flight++;
    endtask

    // One run of values; step 0 gives uniform values, otherwise a wrapping random walk
    task automatic queue_run(int count, logic first_start, int restart_pct, int step);
        logic [VALUE_BITS-1:0] v;
        int                    walk;
        int                    k;
        v = VALUE_BITS'($urandom);
        for (k = 0; k < count; k++) begin
            if (step == 0) begin
                v = VALUE_BITS'($urandom);
            end else begin
                walk = int'(v) + int'($urandom_range(0, 2 * step)) - step;
                v = walk[VALUE_BITS-1:0];
            end
            if (k == 0) begin
                queue_sample(v, first_start);
            end else begin
                queue_sample(v, $urandom_range(99) < restart_pct);
            end
        end
    endtask

    task automatic wait_drained();
        while (samples_in_flight != 0 || expected_lengths.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_gap(logic [GAP_BITS-1:0] gap);
        wait_drained();
        cfg_data <= gap;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        gap_limit = gap;
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_short_runs(int total, int restart_pct);
        int queued;
        int n;
        queued = 0;
        while (queued < total) begin
            n = $urandom_range(1, 30);
            queue_run(n, 1'b1, restart_pct,
                      ($urandom_range(1) == 0) ? 0 : $urandom_range(1, 1500));
            queued += n;
        end
    endtask

    initial begin
        aresetn = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: gap at its reset value of zero
        queue_sample(16'h0000, 1'b1);
        queue_sample(16'h0000, 1'b0);
        queue_sample(16'hFFFF, 1'b0);
        queue_sample(16'hFFFF, 1'b0);
        queue_sample(16'h0000, 1'b0);
        queue_sample(16'h0001, 1'b0);
        write_gap(16'h0001);
        queue_sample(16'h0002, 1'b0);
        queue_sample(16'h0001, 1'b0);
        queue_sample(16'h8000, 1'b1);
        queue_sample(16'h7FFF, 1'b0);
        queue_sample(16'h8001, 1'b0);
        write_gap(16'hFFFF);
        queue_sample(16'h5555, 1'b1);
        queue_sample(16'hAAAA, 1'b0);
        queue_sample(16'h0000, 1'b0);
        queue_sample(16'hFFFF, 1'b0);
        queue_sample(16'h1234, 1'b1);
        write_gap(16'h8000);
        queue_sample(16'h0000, 1'b1);
        queue_sample(16'h8000, 1'b0);
        queue_sample(16'hFFFF, 1'b0);
        queue_sample(16'h8001, 1'b0);

        // no idling, with one long receiver hold-off
        write_gap(GAP_BITS'($urandom_range(0, 2000)));
        queue_short_runs(100, 3);
        holdoff_go = 1'b1;

        write_gap(GAP_BITS'($urandom_range(0, 255)));
        send_idle_pct = 67;
        queue_short_runs(100, 3);

        // with the widest gap every entry chains, so the length keeps growing
        write_gap(16'hFFFF);
        send_idle_pct = 0;
        recv_stall_pct = 67;
        queue_run(170, 1'b1, 0, 300);

        write_gap(GAP_BITS'($urandom_range(0, 4000)));
        send_idle_pct = 37;
        recv_stall_pct = 37;
        queue_run(170, 1'b1, 3, 200);

        wait_drained();
        repeat (MAX_ITEMS + 8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
